@@ rtl/fsc_pkg.sv @@
// Shared constants for the frustum sphere cull core.
// No dependencies.
`default_nettype none

package fsc_pkg;

    localparam int REG_COUNT       = 6;     // plane registers on the config port
    localparam int NUM_PLANES_DEF  = 6;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int PLANE_W         = 64;
    localparam int COORD_W         = 32;
    localparam int RADIUS_W        = 31;
    localparam int R2_W            = 62;
    localparam int MASK_W          = 6;
    localparam int MAG_W           = 50;
    localparam int PROD_W          = 100;

    localparam logic [PLANE_W-1:0] PLANE_RESET = 64'h7FFF_0000_0000_0000;

endpackage

`default_nettype wire

@@ rtl/fsc_lane.sv @@
// One plane of the cull test: dot product, squared magnitudes, exact compare.
// Depends on fsc_pkg. Four register stages, all advanced by en.
`default_nettype none

module fsc_lane
    import fsc_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [PLANE_W-1:0]        plane,
    input  wire logic signed [COORD_W-1:0] x,
    input  wire logic signed [COORD_W-1:0] y,
    input  wire logic signed [COORD_W-1:0] z,
    input  wire logic [R2_W-1:0]           r2,      // aligned with stage 2 outputs
    output logic                           reject
);

    logic signed [15:0] ca, cb, cc, cd;

    assign ca = 16'($signed(plane[COEF_WIDTH-1:0]));
    assign cb = 16'($signed(plane[16+COEF_WIDTH-1:16]));
    assign cc = 16'($signed(plane[32+COEF_WIDTH-1:32]));
    assign cd = 16'($signed(plane[48+COEF_WIDTH-1:48]));

    // stage 1: products
    logic signed [47:0] ax_reg, by_reg, cz_reg;
    logic signed [31:0] aa_reg, bb_reg, cc2_reg;
    // stage 2: plane distance and normal length squared
    logic               neg2_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [32:0]        n2_reg;
    // stage 3: partial products
    logic               neg3_reg;
    logic [49:0]        hh_reg, hl_reg, ll_reg;
    logic [62:0]        rnh_reg;
    logic [64:0]        rnl_reg;
    // stage 4: full squares
    logic               neg4_reg;
    logic [PROD_W-1:0]  ss_reg, tt_reg;

    logic signed [MAG_W-1:0] s_next;
    logic [MAG_W-1:0]        mag_next;
    logic [PROD_W-1:0]       ss_next, tt_next;

    assign s_next = 50'(ax_reg) + 50'(by_reg) + 50'(cz_reg)
                  + {{18{cd[15]}}, cd, 16'b0};
    assign mag_next = s_next[MAG_W-1] ? MAG_W'(-s_next) : MAG_W'(s_next);

    assign ss_next = (PROD_W'(hh_reg) << 50) + (PROD_W'(hl_reg) << 26) + PROD_W'(ll_reg);
    assign tt_next = (PROD_W'(rnh_reg) << 32) + PROD_W'(rnl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= 48'(ca * x);
            by_reg   <= 48'(cb * y);
            cz_reg   <= 48'(cc * z);
            aa_reg   <= 32'(ca * ca);
            bb_reg   <= 32'(cb * cb);
            cc2_reg  <= 32'(cc * cc);

            neg2_reg <= s_next[MAG_W-1] || (s_next == '0);
            mag_reg  <= mag_next;
            n2_reg   <= 33'(aa_reg[30:0]) + 33'(bb_reg[30:0]) + 33'(cc2_reg[30:0]);

            // |s|^2 from 25-bit halves, r^2 * |n|^2 from 30/32-bit halves of r^2
            neg3_reg <= neg2_reg;
            hh_reg   <= 50'(mag_reg[49:25] * mag_reg[49:25]);
            hl_reg   <= 50'(mag_reg[49:25] * mag_reg[24:0]);
            ll_reg   <= 50'(mag_reg[24:0] * mag_reg[24:0]);
            rnh_reg  <= 63'(r2[61:32] * n2_reg);
            rnl_reg  <= 65'(r2[31:0] * n2_reg);

            neg4_reg <= neg3_reg;
            ss_reg   <= ss_next;
            tt_reg   <= tt_next;
        end
    end

    assign reject = neg4_reg && (ss_reg >= tt_reg);

endmodule

`default_nettype wire

@@ rtl/frustum_sphere_cull_core.sv @@
// Frustum sphere cull core, top level.
// Depends on fsc_pkg and fsc_lane.
//
// Input channel (in_valid/in_ready): one sphere per item, center_x/y/z in
// signed Q16.16 and sphere_radius in unsigned Q15.16.
// Output channel (out_valid/out_ready): inside_res and outside_mask, one
// result per sphere, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes plane
// register cfg_index (near, far, bottom, top, left, right); other indexes are
// ignored. cfg_ready is always high. Write only while no item is in flight.
// out_valid rises once the item has passed the four lane stages, the first
// loaded at the edge that accepts the item, and then the output register.
// Throughput: one item per cycle; each plane has its own multiplier lane.
// The whole pipeline advances together; while out_valid is high and
// out_ready is low, in_ready drops and every stage holds, so no item is lost.
// Reset clears all valid bits and loads every plane with a=b=c=0, d=+127.996,
// a plane that never rejects at the default COEF_WIDTH of 16.
`default_nettype none

module frustum_sphere_cull_core
    import fsc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] center_x,
    input  wire logic signed [COORD_W-1:0] center_y,
    input  wire logic signed [COORD_W-1:0] center_z,
    input  wire logic [RADIUS_W-1:0]       sphere_radius,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           inside_res,
    output logic [MASK_W-1:0]              outside_mask,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [PLANE_W-1:0]        cfg_data
);

    localparam int LANES = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;

    logic [PLANE_W-1:0]  plane_reg [REG_COUNT];
    logic [3:0]          vld_reg;
    logic                out_valid_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [R2_W-1:0]     r2_s1_reg, r2_s2_reg;
    logic [MASK_W-1:0]   lane_rej;
    logic                en;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                plane_reg[i] <= PLANE_RESET;
            end
        end
        else if (cfg_valid && (32'(cfg_index) < REG_COUNT))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[2:0], in_valid};
            out_valid_reg <= vld_reg[3];
        end
    end

    // lane results are folded in at the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_s1_reg <= R2_W'(sphere_radius * sphere_radius);
            r2_s2_reg <= r2_s1_reg;
            mask_reg  <= lane_rej;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MASK_W; g++)
        begin : g_lane
            if (g < LANES)
            begin : g_on
                fsc_lane #(
                    .COEF_WIDTH(COEF_WIDTH)
                ) u_lane (
                    .clk    (clk),
                    .en     (en),
                    .plane  (plane_reg[g]),
                    .x      (center_x),
                    .y      (center_y),
                    .z      (center_z),
                    .r2     (r2_s2_reg),
                    .reject (lane_rej[g])
                );
            end
            else
            begin : g_off
                assign lane_rej[g] = 1'b0;
            end
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign outside_mask = mask_reg;
    assign inside_res   = (mask_reg == '0);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(outside_mask)))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item not tracked in pipeline");

endmodule

`default_nettype wire
